FILE: design/vie_pkg.sv
// shared types and codes for the instruction execute block
// no dependencies; imported by the ram, the top level and the testbench
package vie_pkg;

   // storage geometry
   localparam int REG_DEPTH  = 16;
   localparam int REG_WIDTH  = 8;
   localparam int MEM_DEPTH  = 256;
   localparam int MEM_WIDTH  = 8;

   // action codes carried in tuser
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_EXEC  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // opcodes
   localparam logic [3:0] OP_LOAD_MEM = 4'h1;
   localparam logic [3:0] OP_LOAD_IMM = 4'h2;
   localparam logic [3:0] OP_STORE    = 4'h3;
   localparam logic [3:0] OP_MOVE     = 4'h4;
   localparam logic [3:0] OP_ADD      = 4'h5;
   localparam logic [3:0] OP_OR_ALT   = 4'h6;
   localparam logic [3:0] OP_OR       = 4'h7;
   localparam logic [3:0] OP_AND      = 4'h8;
   localparam logic [3:0] OP_XOR      = 4'h9;
   localparam logic [3:0] OP_ROTATE   = 4'hA;
   localparam logic [3:0] OP_JUMP     = 4'hB;
   localparam logic [3:0] OP_HALT     = 4'hC;

   // one input beat held in the execute stage
   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  address;
      logic [7:0]  data_byte;
      logic [15:0] instruction;
   } item_type;

   // one result beat, laid out as in rsp_tdata, members listed from the top bit down
   typedef struct packed {
      logic       halted;
      logic [7:0] jump_target;
      logic       jump_taken;
      logic [7:0] read_byte;
   } result_type;

endpackage

FILE: design/vole_instruction_execute_top.sv
// top level of the instruction execute block: issue, execute and result queue
// depends on vie_pkg and vie_ram
//
// Usage: each beat on the req channel is one item. req_tuser carries the
// action (write memory byte, execute instruction, read memory byte) and
// req_tdata the address, data byte and 16-bit instruction. Every item gives
// exactly one beat on the rsp channel with the read byte, the jump flag and
// target, and the halt flag, in input order.
// The register file and data memory are read at the accepting edge, and the
// following cycle executes, writes back and loads the result queue, which
// raises rsp_tvalid. Throughput is one item per cycle while the output queue
// has room, set by the single read-modify-write pass through the rams;
// a write by one item is forwarded to the item right behind it.
// Reset clears all registers and memory bytes at once through per-entry
// valid bits; req_tready is low while reset is high, and an item may be sent
// on the first cycle after reset.
// When the receiver stalls, up to three results are held in the output
// queue and req_tready drops once the queued results plus the item in the
// execute stage reach three.
module vole_instruction_execute_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // address[7:0], data_byte[15:8], instruction[31:16]
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // read_byte[7:0], jump_taken[8], jump_target[16:9],
                                   // halted[17], zero fill[23:18]
);
   import vie_pkg::*;

   localparam int RA_W     = $clog2(REG_DEPTH);
   localparam int MA_W     = $clog2(MEM_DEPTH);
   localparam int OQ_DEPTH = 3;

   // ---------------------------------------------------------------- issue
   item_type        req_item;
   logic            req_fire;
   logic [3:0]      req_op;
   logic [RA_W-1:0] req_addr_a;
   logic [RA_W-1:0] req_addr_b;
   logic [MA_W-1:0] req_mem_addr;

   assign req_item.action      = req_tuser;
   assign req_item.address     = req_tdata[7:0];
   assign req_item.data_byte   = req_tdata[15:8];
   assign req_item.instruction = req_tdata[31:16];
   assign req_fire             = req_tvalid & req_tready;
   assign req_op               = req_item.instruction[15:12];

   // port a reads the x register for move and the add, or, and, xor ops, otherwise r
   assign req_addr_a = ((req_op >= OP_MOVE) && (req_op <= OP_XOR)) ?
                       req_item.instruction[7:4] : req_item.instruction[11:8];
   assign req_addr_b = req_item.instruction[3:0];
   assign req_mem_addr = (req_item.action == ACT_EXEC) ?
                         req_item.instruction[7:0] : req_item.address;

   // execute stage registers
   item_type        s1_ff, s1_in;
   logic            s1_valid_ff, s1_valid_in;
   logic [RA_W-1:0] s1_addr_a_ff, s1_addr_a_in;
   logic [RA_W-1:0] s1_addr_b_ff, s1_addr_b_in;
   logic [MA_W-1:0] s1_mem_addr_ff, s1_mem_addr_in;

   assign s1_valid_in    = req_fire;
   assign s1_in          = req_item;
   assign s1_addr_a_in   = req_addr_a;
   assign s1_addr_b_in   = req_addr_b;
   assign s1_mem_addr_in = req_mem_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_ff          <= s1_in;
      s1_addr_a_ff   <= s1_addr_a_in;
      s1_addr_b_ff   <= s1_addr_b_in;
      s1_mem_addr_ff <= s1_mem_addr_in;
   end

   // ---------------------------------------------------------------- memories
   logic                 reg_we;
   logic [RA_W-1:0]      reg_waddr;
   logic [REG_WIDTH-1:0] reg_wdata;
   logic                 mem_we;
   logic [MA_W-1:0]      mem_waddr;
   logic [MEM_WIDTH-1:0] mem_wdata;
   logic [REG_WIDTH-1:0] reg_a_q;
   logic [REG_WIDTH-1:0] reg_b_q;
   logic [MEM_WIDTH-1:0] mem_q;

   // register file kept as two copies to give two read ports
   vie_ram #(.WIDTH(REG_WIDTH), .DEPTH(REG_DEPTH)) u_reg_a (
      .clock   (clock),
      .wr_en   (reg_we),
      .wr_addr (reg_waddr),
      .wr_data (reg_wdata),
      .rd_addr (req_addr_a),
      .rd_data (reg_a_q)
   );

   vie_ram #(.WIDTH(REG_WIDTH), .DEPTH(REG_DEPTH)) u_reg_b (
      .clock   (clock),
      .wr_en   (reg_we),
      .wr_addr (reg_waddr),
      .wr_data (reg_wdata),
      .rd_addr (req_addr_b),
      .rd_data (reg_b_q)
   );

   vie_ram #(.WIDTH(MEM_WIDTH), .DEPTH(MEM_DEPTH)) u_data_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (req_mem_addr),
      .rd_data (mem_q)
   );

   // valid bits, last write for forwarding, and a shadow copy of register 0
   logic [REG_DEPTH-1:0] reg_vld_ff, reg_vld_in;
   logic [MEM_DEPTH-1:0] mem_vld_ff, mem_vld_in;
   logic                 fwd_reg_valid_ff, fwd_reg_valid_in;
   logic [RA_W-1:0]      fwd_reg_addr_ff, fwd_reg_addr_in;
   logic [REG_WIDTH-1:0] fwd_reg_data_ff, fwd_reg_data_in;
   logic                 fwd_mem_valid_ff, fwd_mem_valid_in;
   logic [MA_W-1:0]      fwd_mem_addr_ff, fwd_mem_addr_in;
   logic [MEM_WIDTH-1:0] fwd_mem_data_ff, fwd_mem_data_in;
   logic [REG_WIDTH-1:0] reg0_ff, reg0_in;

   always_comb begin
      reg_vld_in = reg_vld_ff;
      mem_vld_in = mem_vld_ff;
      reg0_in    = reg0_ff;
      if (reg_we) begin
         reg_vld_in[reg_waddr] = 1'b1;
         if (reg_waddr == RA_W'(0)) begin
            reg0_in = reg_wdata;
         end
      end
      if (mem_we) begin
         mem_vld_in[mem_waddr] = 1'b1;
      end
   end

   assign fwd_reg_valid_in = reg_we;
   assign fwd_reg_addr_in  = reg_waddr;
   assign fwd_reg_data_in  = reg_wdata;
   assign fwd_mem_valid_in = mem_we;
   assign fwd_mem_addr_in  = mem_waddr;
   assign fwd_mem_data_in  = mem_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff       <= '0;
         mem_vld_ff       <= '0;
         reg0_ff          <= '0;
         fwd_reg_valid_ff <= 1'b0;
         fwd_mem_valid_ff <= 1'b0;
      end else begin
         reg_vld_ff       <= reg_vld_in;
         mem_vld_ff       <= mem_vld_in;
         reg0_ff          <= reg0_in;
         fwd_reg_valid_ff <= fwd_reg_valid_in;
         fwd_mem_valid_ff <= fwd_mem_valid_in;
      end
      fwd_reg_addr_ff <= fwd_reg_addr_in;
      fwd_reg_data_ff <= fwd_reg_data_in;
      fwd_mem_addr_ff <= fwd_mem_addr_in;
      fwd_mem_data_ff <= fwd_mem_data_in;
   end

   // ---------------------------------------------------------------- execute
   logic [REG_WIDTH-1:0] val_a;
   logic [REG_WIDTH-1:0] val_b;
   logic [MEM_WIDTH-1:0] val_m;
   logic [3:0]           s1_op;
   logic [3:0]           s1_r;
   logic [3:0]           s1_y;
   logic [7:0]           s1_xy;
   logic [15:0]          rot_dbl;
   result_type           s1_result;

   assign s1_op = s1_ff.instruction[15:12];
   assign s1_r  = s1_ff.instruction[11:8];
   assign s1_y  = s1_ff.instruction[3:0];
   assign s1_xy = s1_ff.instruction[7:0];

   // operand values: forwarded write, ram data, or zero before first write
   always_comb begin
      if (fwd_reg_valid_ff && (fwd_reg_addr_ff == s1_addr_a_ff)) begin
         val_a = fwd_reg_data_ff;
      end else if (reg_vld_ff[s1_addr_a_ff]) begin
         val_a = reg_a_q;
      end else begin
         val_a = '0;
      end
      if (fwd_reg_valid_ff && (fwd_reg_addr_ff == s1_addr_b_ff)) begin
         val_b = fwd_reg_data_ff;
      end else if (reg_vld_ff[s1_addr_b_ff]) begin
         val_b = reg_b_q;
      end else begin
         val_b = '0;
      end
      if (fwd_mem_valid_ff && (fwd_mem_addr_ff == s1_mem_addr_ff)) begin
         val_m = fwd_mem_data_ff;
      end else if (mem_vld_ff[s1_mem_addr_ff]) begin
         val_m = mem_q;
      end else begin
         val_m = '0;
      end
   end

   // rotate right by the low three bits of y
   assign rot_dbl = {val_a, val_a} >> s1_y[2:0];

   // decode, alu and write-back
   always_comb begin
      s1_result = '0;
      reg_we    = 1'b0;
      reg_waddr = s1_r;
      reg_wdata = '0;
      mem_we    = 1'b0;
      mem_waddr = s1_mem_addr_ff;
      mem_wdata = s1_ff.data_byte;
      unique case (s1_ff.action)
         ACT_WRITE: begin
            mem_we              = 1'b1;
            s1_result.read_byte = s1_ff.data_byte;
         end
         ACT_READ: begin
            s1_result.read_byte = val_m;
         end
         ACT_EXEC: begin
            unique case (s1_op)
               OP_LOAD_MEM: begin
                  reg_we    = 1'b1;
                  reg_wdata = val_m;
               end
               OP_LOAD_IMM: begin
                  reg_we    = 1'b1;
                  reg_wdata = s1_xy;
               end
               OP_STORE: begin
                  mem_we              = 1'b1;
                  mem_wdata           = val_a;
                  s1_result.read_byte = val_a;
               end
               OP_MOVE: begin
                  reg_we    = 1'b1;
                  reg_waddr = s1_y;
                  reg_wdata = val_a;
               end
               OP_ADD: begin
                  reg_we    = 1'b1;
                  reg_wdata = val_a + val_b;
               end
               OP_OR_ALT, OP_OR: begin
                  reg_we    = 1'b1;
                  reg_wdata = val_a | val_b;
               end
               OP_AND: begin
                  reg_we    = 1'b1;
                  reg_wdata = val_a & val_b;
               end
               OP_XOR: begin
                  reg_we    = 1'b1;
                  reg_wdata = val_a ^ val_b;
               end
               OP_ROTATE: begin
                  reg_we    = 1'b1;
                  reg_wdata = rot_dbl[7:0];
               end
               OP_JUMP: begin
                  if (val_a == reg0_ff) begin
                     s1_result.jump_taken  = 1'b1;
                     s1_result.jump_target = s1_xy;
                  end
               end
               OP_HALT: begin
                  s1_result.halted = 1'b1;
               end
               default: begin
               end
            endcase
            if (reg_we) begin
               s1_result.read_byte = reg_wdata;
            end
         end
         default: begin
         end
      endcase
      reg_we = reg_we & s1_valid_ff;
      mem_we = mem_we & s1_valid_ff;
   end

   // ---------------------------------------------------------------- result queue
   result_type q_ff [OQ_DEPTH];
   result_type q_in [OQ_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       q_push;
   logic       q_pop;
   logic [2:0] in_flight;

   assign q_push    = s1_valid_ff;
   assign q_pop     = rsp_tvalid & rsp_tready;
   assign in_flight = {1'b0, count_ff} + {2'b00, s1_valid_ff};

   // room for every item already past issue plus this one, none during reset
   assign req_tready = (in_flight < 3'(OQ_DEPTH)) & ~reset;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {6'b0, q_ff[rd_ptr_ff]};

   always_comb begin
      q_in      = q_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push) begin
         q_in[wr_ptr_ff] = s1_result;
         wr_ptr_in = (wr_ptr_ff == 2'(OQ_DEPTH - 1)) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == 2'(OQ_DEPTH - 1)) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      priority if (q_push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (q_pop && !q_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      q_ff <= q_in;
   end

endmodule

FILE: design/vie_ram.sv
// generic single write, single read ram with registered read data
// uses vie_pkg for default geometry only
module vie_ram #(
   parameter int WIDTH = vie_pkg::REG_WIDTH,
   parameter int DEPTH = vie_pkg::REG_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import vie_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read, read returns the old value on collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sim/tb_vole_instruction_execute_top.sv
// self-checking testbench for vole_instruction_execute_top: directed and random beats
// depends on vie_pkg and the design sources; keeps its own register file and memory copy
module tb_vole_instruction_execute_top;
   import vie_pkg::*;

   // codes the package leaves unnamed
   localparam logic [1:0] ACT_NONE    = 2'd3;
   localparam logic [3:0] OP_UNUSED_0 = 4'h0;
   localparam logic [3:0] OP_UNUSED_D = 4'hD;
   localparam logic [3:0] OP_UNUSED_E = 4'hE;
   localparam logic [3:0] OP_UNUSED_F = 4'hF;

   localparam int ITEMS_PER_PHASE = 550;
   localparam int STALL_LIMIT     = 5000;
   localparam int DRAIN_CYCLES    = 10;
   localparam logic [7:0] CORNER_BYTES [4] = '{8'h00, 8'hFF, 8'h80, 8'h01};

   // expected results and the machine state they follow from
   class vole_scoreboard;
      logic [7:0]  regs [REG_DEPTH];
      logic [7:0]  mem [MEM_DEPTH];
      result_type  pending_results [$];
      int unsigned mismatches;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         mismatches = 0;
      endfunction

      // one step of the machine, returns the beat it must produce
      function result_type execute_item(item_type it);
         result_type  res;
         logic [3:0]  op, r, x, y;
         logic [7:0]  xy, a, b;
         logic [15:0] spun;
         res = '0;
         op = it.instruction[15:12];
         r = it.instruction[11:8];
         x = it.instruction[7:4];
         y = it.instruction[3:0];
         xy = it.instruction[7:0];
         a = regs[x];
         b = regs[y];
         case (it.action)
            ACT_WRITE: begin
               mem[it.address] = it.data_byte;
               res.read_byte = it.data_byte;
            end
            ACT_READ: res.read_byte = mem[it.address];
            ACT_EXEC: begin
               case (op)
                  OP_LOAD_MEM: begin
                     regs[r] = mem[xy];
                     res.read_byte = regs[r];
                  end
                  OP_LOAD_IMM: begin
                     regs[r] = xy;
                     res.read_byte = regs[r];
                  end
                  OP_STORE: begin
                     mem[xy] = regs[r];
                     res.read_byte = mem[xy];
                  end
                  OP_MOVE: begin
                     regs[y] = regs[x];
                     res.read_byte = regs[y];
                  end
                  OP_ADD: begin
                     regs[r] = a + b;
                     res.read_byte = regs[r];
                  end
                  OP_OR_ALT, OP_OR: begin
                     regs[r] = a | b;
                     res.read_byte = regs[r];
                  end
                  OP_AND: begin
                     regs[r] = a & b;
                     res.read_byte = regs[r];
                  end
                  OP_XOR: begin
                     regs[r] = a ^ b;
                     res.read_byte = regs[r];
                  end
                  OP_ROTATE: begin
                     // rotation by n acts as one by n mod 8
                     spun = {regs[r], regs[r]} >> y[2:0];
                     regs[r] = spun[7:0];
                     res.read_byte = regs[r];
                  end
                  OP_JUMP: begin
                     if (regs[r] == regs[0]) begin
                        res.jump_taken = 1'b1;
                        res.jump_target = xy;
                     end
                  end
                  OP_HALT: res.halted = 1'b1;
                  default: ;
               endcase
            end
            default: ;
         endcase
         return res;
      endfunction

      function void note_item(item_type it);
         pending_results.push_back(execute_item(it));
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: rb %h jt %b tgt %h halt %b",
                        got.read_byte, got.jump_taken, got.jump_target, got.halted);
            return;
         end
         want = pending_results.pop_front();
         if (got.read_byte !== want.read_byte || got.jump_taken !== want.jump_taken ||
             got.jump_target !== want.jump_target || got.halted !== want.halted) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: want rb %h jt %b tgt %h hlt %b, got rb %h jt %b tgt %h hlt %b",
                        want.read_byte, want.jump_taken, want.jump_target, want.halted,
                        got.read_byte, got.jump_taken, got.jump_target, got.halted);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // address[7:0], data_byte[15:8], instruction[31:16]
   logic [1:0]  req_tuser = '0;  // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // read_byte[7:0], jump_taken[8], jump_target[16:9],
                                 // halted[17], zero fill[23:18]

   int unsigned req_gap_pct = 33;
   int unsigned rsp_stall_pct = 83;

   vole_scoreboard exec_sb = new();

   vole_instruction_execute_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock, 12 units per period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // note accepted requests and check accepted results
   always @(posedge clock) begin : monitor
      item_type beat;
      if (!reset) begin
         beat.action = req_tuser;
         beat.address = req_tdata[7:0];
         beat.data_byte = req_tdata[15:8];
         beat.instruction = req_tdata[31:16];
         if (req_tvalid && req_tready)
            exec_sb.note_item(beat);
         if (rsp_tvalid && rsp_tready)
            exec_sb.check_result(rsp_tdata[$bits(result_type)-1:0]);
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [15:0] instr(logic [3:0] op, logic [3:0] r, logic [7:0] xy);
      return {op, r, xy};
   endfunction

   // mostly well-formed instructions with random content, plus noise
   function automatic item_type random_item();
      item_type   it;
      int unsigned pick;
      logic [3:0] op;
      it.action = ACT_EXEC;
      it.address = 8'($urandom_range(255));
      it.data_byte = 8'($urandom_range(255));
      it.instruction = 16'($urandom_range(16'hFFFF));
      pick = $urandom_range(99);
      if (pick < 12)
         it.action = ACT_WRITE;
      else if (pick < 22)
         it.action = ACT_READ;
      else if (pick < 25)
         it.action = ACT_NONE;
      // keep half the memory traffic in a small window so reads hit stored bytes
      if (it.action != ACT_EXEC && $urandom_range(1))
         it.address[7:4] = 4'h0;
      if (it.action == ACT_WRITE && $urandom_range(2) == 0)
         it.data_byte = CORNER_BYTES[2'($urandom_range(3))];
      if (it.action == ACT_EXEC && $urandom_range(99) < 85) begin
         op = 4'($urandom_range(OP_LOAD_MEM, OP_HALT));
         it.instruction[15:12] = op;
         case (op)
            OP_LOAD_MEM, OP_STORE: begin
               if ($urandom_range(1))
                  it.instruction[7:4] = 4'h0;
            end
            OP_LOAD_IMM: begin
               // repeated values make jump conditions hold more often
               if ($urandom_range(2) == 0)
                  it.instruction[7:0] = CORNER_BYTES[2'($urandom_range(3))];
            end
            OP_JUMP: begin
               if ($urandom_range(3) == 0)
                  it.instruction[11:8] = 4'h0;
            end
            default: ;
         endcase
      end
      return it;
   endfunction

   // present one request beat and hold it until accepted
   task automatic send_item(input item_type it);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.action;
      req_tdata <= {it.instruction, it.data_byte, it.address};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic send_exec(input logic [15:0] ins);
      send_item('{ACT_EXEC, 8'h00, 8'h00, ins});
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: memory extremes, every opcode, rotate and jump corners
      send_item('{ACT_WRITE, 8'hFF, 8'hA5, 16'hFFFF});
      send_item('{ACT_WRITE, 8'h00, 8'hFF, 16'h0000});
      send_item('{ACT_READ, 8'hFF, 8'h00, 16'h0000});
      send_item('{ACT_READ, 8'h7E, 8'hFF, 16'hFFFF});
      send_exec(instr(OP_LOAD_IMM, 4'hF, 8'hFF));
      send_exec(instr(OP_LOAD_IMM, 4'h1, 8'h81));
      send_exec(instr(OP_LOAD_MEM, 4'hA, 8'hFF));
      send_exec(instr(OP_STORE, 4'hF, 8'h10));
      send_item('{ACT_READ, 8'h10, 8'h00, 16'h0000});
      send_exec(instr(OP_MOVE, 4'h0, {4'hF, 4'h2}));
      // move ignores the opcode's register nibble
      send_exec(instr(OP_MOVE, 4'hB, {4'h1, 4'hC}));
      send_exec(instr(OP_ADD, 4'h3, {4'hF, 4'h1}));
      send_exec(instr(OP_OR_ALT, 4'h4, {4'h1, 4'hA}));
      send_exec(instr(OP_OR, 4'h5, {4'h1, 4'hA}));
      send_exec(instr(OP_AND, 4'h6, {4'hF, 4'hA}));
      send_exec(instr(OP_XOR, 4'h7, {4'hF, 4'hA}));
      // rotate by zero, one, eight and fifteen places
      send_exec(instr(OP_ROTATE, 4'h1, 8'hF0));
      send_exec(instr(OP_ROTATE, 4'h1, 8'h01));
      send_exec(instr(OP_ROTATE, 4'h1, 8'h08));
      send_exec(instr(OP_ROTATE, 4'h1, 8'h0F));
      // jump taken on register zero, not taken, taken on an equal register
      send_exec(instr(OP_JUMP, 4'h0, 8'hFF));
      send_exec(instr(OP_JUMP, 4'h1, 8'hAB));
      send_exec(instr(OP_LOAD_IMM, 4'h5, 8'h00));
      send_exec(instr(OP_JUMP, 4'h5, 8'hCD));
      send_exec(instr(OP_HALT, 4'h0, 8'h00));
      send_exec(instr(OP_UNUSED_0, 4'h3, 8'h23));
      send_exec(instr(OP_UNUSED_D, 4'h2, 8'h5A));
      send_exec(instr(OP_UNUSED_E, 4'h9, 8'hC3));
      send_exec(instr(OP_UNUSED_F, 4'hF, 8'hFF));
      send_item('{ACT_NONE, 8'h55, 8'hAA, 16'h1234});

      // random beats under three idling patterns
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_gap_pct = 33;
               rsp_stall_pct = 83;
            end
            1: begin
               req_gap_pct = 83;
               rsp_stall_pct = 33;
            end
            default: begin
               req_gap_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_item(random_item());
      end
      req_tvalid <= 1'b0;

      // drain outstanding results
      while (exec_sb.pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (exec_sb.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: vole_instruction_execute_top.f
design/vie_pkg.sv
design/vie_ram.sv
design/vole_instruction_execute_top.sv
sim/tb_vole_instruction_execute_top.sv
